// ===== design/thb_pkg.sv =====
// ----------------------------------------------------------------------------
// thb_pkg
// Shared types and codes for the threshold histogram binner.
// ----------------------------------------------------------------------------
`default_nettype none

package thb_pkg;

  // item function codes
  localparam logic [1:0] FUNC_WR_EDGE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE  = 2'd2;
  localparam logic [1:0] FUNC_READOUT = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BIN = 2'd0;
  localparam logic [1:0] KIND_BAD = 2'd1;
  localparam logic [1:0] KIND_SUM = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_EDGES   = 2'd0;
  localparam logic [1:0] CFG_BAD_VALUE   = 2'd1;
  localparam logic [1:0] CFG_ZERO_ANCHOR = 2'd2;

  localparam logic [31:0] MIN_CAP = 32'd9999;

  typedef struct packed {
    logic [1:0]         func;
    logic [4:0]         edge_index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  bin_index;
    logic [31:0] count;
    logic [31:0] count_min;
    logic [31:0] count_max;
    logic        last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic edge_wr;
    logic clear;
    logic latch;
    logic bad_bump;
    logic idx_clr;
    logic idx_inc;
    logic bin_load_idx;
    logic bin_load_n;
    logic edge_rd;
    logic cnt_rd;
    logic cnt_rd_bin;
    logic cnt_wr;
    logic stats_init;
    logic emit_bin;
    logic emit_bad;
    logic emit_sum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_bad;
    logic n_zero;
    logic less;
    logic last_edge;
    logic at_n;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/threshold_histogram_binner.sv =====
// Steps: a write edge or clear item is done on accept, as is a sample equal to bad_value.
// Any other sample is accepted, then each edge searched is read from edge memory and
// compared, then the bin count gets a read-modify-write. A readout reads and emits the
// n+1 bins in turn, n = min(num_edges, MAX_EDGES), then the bad count and the summary;
// each result shows in the cycle after its emit step and the receiver cannot stall it.
// Reset clears config to defaults and all counts at once through per-bin valid bits.
// ----------------------------------------------------------------------------
// threshold_histogram_binner
// Histogram with a programmable edge table, bad-value counter and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_histogram_binner
  import thb_pkg::*;
#(
  parameter int MAX_EDGES  = 32,
  parameter int COUNT_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_wdata_i,
  input  wire         start,
  output logic        busy,
  input  item_t       item_i,
  output logic        result_strobe_o,
  output result_t     result_o
);

  cmd_t cmd;
  sts_t sts;

  thb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (item_i.func),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  thb_dp #(
    .MAX_EDGES (MAX_EDGES),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// ===== design/thb_ctrl.sv =====
// ----------------------------------------------------------------------------
// thb_ctrl
// Sequencer for edge writes, clears, edge search, count update and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module thb_ctrl
  import thb_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  wire  [1:0] func_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_BUMP_RD  = 4'd3;
  localparam logic [3:0] S_BUMP_WR  = 4'd4;
  localparam logic [3:0] S_RO_RD    = 4'd5;
  localparam logic [3:0] S_RO_EMIT  = 4'd6;
  localparam logic [3:0] S_BAD_EMIT = 4'd7;
  localparam logic [3:0] S_SUM_EMIT = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FUNC_WR_EDGE: cmd_o.edge_wr = 1'b1;
            FUNC_CLEAR:   cmd_o.clear   = 1'b1;
            FUNC_SAMPLE: begin
              cmd_o.latch = 1'b1;
              if (sts_i.in_is_bad) begin
                cmd_o.bad_bump = 1'b1;
              end else if (sts_i.n_zero) begin
                cmd_o.bin_load_n = 1'b1;
                state_d          = S_BUMP_RD;
              end else begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_SCAN_RD;
              end
            end
            FUNC_READOUT: begin
              cmd_o.idx_clr    = 1'b1;
              cmd_o.stats_init = 1'b1;
              state_d          = S_RO_RD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.less) begin
          cmd_o.bin_load_idx = 1'b1;
          state_d            = S_BUMP_RD;
        end else if (sts_i.last_edge) begin
          cmd_o.bin_load_n = 1'b1;
          state_d          = S_BUMP_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_BUMP_RD: begin
        cmd_o.cnt_rd     = 1'b1;
        cmd_o.cnt_rd_bin = 1'b1;
        state_d          = S_BUMP_WR;
      end
      S_BUMP_WR: begin
        cmd_o.cnt_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_RO_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = S_RO_EMIT;
      end
      S_RO_EMIT: begin
        cmd_o.emit_bin = 1'b1;
        if (sts_i.at_n) begin
          state_d = S_BAD_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RO_RD;
        end
      end
      S_BAD_EMIT: begin
        cmd_o.emit_bad = 1'b1;
        state_d        = S_SUM_EMIT;
      end
      S_SUM_EMIT: begin
        cmd_o.emit_sum = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTH
  // a readout always closes with the bad count and then the summary
  a_bad_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BAD_EMIT |=> state_q == S_SUM_EMIT)
    else $error("bad count not followed by summary");

  // a count update is always a read then a write of the same bin
  a_bump_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BUMP_RD |=> state_q == S_BUMP_WR)
    else $error("count read not followed by write");

  // new items only enter from idle
  a_no_entry_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !(cmd_o.latch || cmd_o.edge_wr || cmd_o.clear))
    else $error("item taken while busy");
`endif

endmodule

`default_nettype wire

// ===== design/thb_dp.sv =====
// ----------------------------------------------------------------------------
// thb_dp
// Datapath: config registers, edge memory, count memory, counters and results.
// ----------------------------------------------------------------------------
`default_nettype none

module thb_dp
  import thb_pkg::*;
#(
  parameter int MAX_EDGES  = 32,
  parameter int COUNT_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [31:0] cfg_wdata_i,
  input  item_t       item_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        result_strobe_o,
  output result_t     result_o
);

  localparam int CA_W = $clog2(MAX_EDGES + 1);
  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  // configuration
  logic [5:0]         num_edges_q;
  logic signed [31:0] bad_value_q;
  logic               zero_anchor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_edges_q   <= '0;
      bad_value_q   <= '0;
      zero_anchor_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_EDGES:   num_edges_q   <= cfg_wdata_i[5:0];
        CFG_BAD_VALUE:   bad_value_q   <= cfg_wdata_i;
        CFG_ZERO_ANCHOR: zero_anchor_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // bins in use, overflow bin sits at index n
  logic [CA_W-1:0] n_w;
  always_comb begin
    if (32'(num_edges_q) > 32'(MAX_EDGES)) begin
      n_w = CA_W'(MAX_EDGES);
    end else begin
      n_w = CA_W'(num_edges_q);
    end
  end

  // sample and walk index
  logic signed [31:0] sample_q;
  logic [CA_W-1:0]    idx_q, idx_nxt;
  logic [CA_W-1:0]    bin_q;

  assign idx_nxt = idx_q + CA_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      bin_q <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_nxt;
      end
      if (cmd_i.bin_load_idx) begin
        bin_q <= idx_q;
      end else if (cmd_i.bin_load_n) begin
        bin_q <= n_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sample_q <= item_i.value;
    end
  end

  // edge table
  logic signed [31:0] edge_mem [MAX_EDGES];
  logic signed [31:0] edge_rdata_q;
  logic [31:0]        edge_wr_ext, idx_ext;
  logic [EA_W-1:0]    edge_wr_addr, edge_rd_addr;

  assign edge_wr_ext  = 32'(item_i.edge_index);
  assign edge_wr_addr = edge_wr_ext[EA_W-1:0];
  assign idx_ext      = 32'(idx_q);
  assign edge_rd_addr = idx_ext[EA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr && (edge_wr_ext < 32'(MAX_EDGES))) begin
      edge_mem[edge_wr_addr] <= item_i.value;
    end
    if (cmd_i.edge_rd) begin
      edge_rdata_q <= edge_mem[edge_rd_addr];
    end
  end

  // bin counts, an entry with its valid bit clear reads as zero
  logic [COUNT_BITS-1:0] cnt_mem [MAX_EDGES+1];
  logic [MAX_EDGES:0]    cnt_vld_q;
  logic [COUNT_BITS-1:0] cnt_rdata_q;
  logic                  cnt_rvld_q;
  logic [CA_W-1:0]       cnt_rd_addr;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_inc;

  assign cnt_rd_addr = cmd_i.cnt_rd_bin ? bin_q : idx_q;
  assign cnt_cur     = cnt_rvld_q ? cnt_rdata_q : '0;
  assign cnt_inc     = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd) begin
      cnt_rdata_q <= cnt_mem[cnt_rd_addr];
    end
    if (cmd_i.cnt_wr) begin
      cnt_mem[bin_q] <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q  <= '0;
      cnt_rvld_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_rd) begin
        cnt_rvld_q <= cnt_vld_q[cnt_rd_addr];
      end
      if (cmd_i.clear) begin
        cnt_vld_q <= '0;
      end else if (cmd_i.cnt_wr) begin
        cnt_vld_q[bin_q] <= 1'b1;
      end
    end
  end

  // bad counter
  logic [COUNT_BITS-1:0] bad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= '0;
    end else if (cmd_i.clear) begin
      bad_q <= '0;
    end else if (cmd_i.bad_bump && !(&bad_q)) begin
      bad_q <= bad_q + COUNT_BITS'(1);
    end
  end

  // counts that do not fit in 32 bits report as all ones
  logic [COUNT_BITS-1:0] rep_src;
  logic [63:0]           rep_ext;
  logic [31:0]           rep;

  assign rep_src = cmd_i.emit_bad ? bad_q : cnt_cur;
  assign rep_ext = 64'(rep_src);
  assign rep     = (|rep_ext[63:32]) ? 32'hFFFF_FFFF : rep_ext[31:0];

  // running limits over a readout
  logic [31:0] min_q, max_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_CAP;
      max_q <= '0;
    end else if (cmd_i.stats_init) begin
      min_q <= MIN_CAP;
      max_q <= '0;
    end else if (cmd_i.emit_bin || cmd_i.emit_bad) begin
      if (rep < min_q) begin
        min_q <= rep;
      end
      if (rep > max_q) begin
        max_q <= rep;
      end
    end
  end

  // result register
  result_t res_d, res_q;
  logic    strobe_q;
  logic [31:0] bin_ext;

  assign bin_ext = 32'(idx_q);

  always_comb begin
    res_d = '0;
    if (cmd_i.emit_bin) begin
      res_d.kind      = KIND_BIN;
      res_d.bin_index = bin_ext[5:0];
      res_d.count     = rep;
    end else if (cmd_i.emit_bad) begin
      res_d.kind  = KIND_BAD;
      res_d.count = rep;
    end else begin
      res_d.kind      = KIND_SUM;
      res_d.count_min = zero_anchor_q ? '0 : min_q;
      res_d.count_max = max_q;
      res_d.last      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_bin || cmd_i.emit_bad || cmd_i.emit_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_bin || cmd_i.emit_bad || cmd_i.emit_sum) begin
      res_q <= res_d;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

  // status
  assign sts_o.in_is_bad = (item_i.value == bad_value_q);
  assign sts_o.n_zero    = (n_w == '0);
  assign sts_o.less      = (sample_q < edge_rdata_q);
  assign sts_o.last_edge = (idx_nxt == n_w);
  assign sts_o.at_n      = (idx_q == n_w);

`ifndef SYNTH
  // the walk never passes the overflow bin
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_bin || cmd_i.edge_rd) |-> idx_q <= n_w)
    else $error("bin walk past overflow bin");

  // updates only land on bins in use
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_wr |-> bin_q <= n_w)
    else $error("count update beyond overflow bin");

  // the closing flag rides only on a summary
  a_last_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && res_q.last) |-> (res_q.kind == KIND_SUM && $past(cmd_i.emit_sum)))
    else $error("last flag on a non-summary result");
`endif

endmodule

`default_nettype wire

// ===== dv/threshold_histogram_binner_test.sv =====
// ----------------------------------------------------------------------------
// threshold_histogram_binner_test
// Self-checking bench for the histogram binner: drives edge writes, clears,
// samples and readouts through the command port, keeps its own histogram of
// what the block should hold, and checks every readout result field by field.
// ----------------------------------------------------------------------------
module threshold_histogram_binner_test;
  import thb_pkg::*;

  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int NUM_SLOTS      = 32;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  item_t       item_d;
  logic        result_strobe_o;
  result_t     result_o;

  threshold_histogram_binner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start           (start),
    .busy            (busy),
    .item_i          (item_d),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected histogram state
  logic signed [31:0] edge_tab [NUM_SLOTS];
  logic [31:0]        bin_cnt [NUM_SLOTS + 1];
  logic [31:0]        bad_cnt;
  logic [5:0]         ne_reg;
  logic signed [31:0] bad_val_reg;
  logic               anchor_reg;

  result_t readout_due_q [$];

  int n_errors;
  int n_items;
  int n_samples;
  int n_readouts;
  int n_results;
  int n_cfg_writes;
  int stall_cycles = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  function automatic int unsigned edges_in_use();
    return (ne_reg > 6'(NUM_SLOTS)) ? NUM_SLOTS : int'(ne_reg);
  endfunction

  // first edge strictly above the sample, else the overflow bin
  function automatic int unsigned pick_bin(logic signed [31:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (v < edge_tab[i]) return i;
    return n;
  endfunction

  task automatic account_item(item_t it);
    int unsigned n;
    int unsigned b;
    logic [31:0] cmin;
    logic [31:0] cmax;
    result_t     r;
    n = edges_in_use();
    case (it.func)
      FUNC_WR_EDGE: edge_tab[it.edge_index] = it.value;
      FUNC_CLEAR: begin
        foreach (bin_cnt[i]) bin_cnt[i] = '0;
        bad_cnt = '0;
      end
      FUNC_SAMPLE: begin
        n_samples++;
        if (it.value == bad_val_reg) begin
          if (bad_cnt != '1) bad_cnt++;
        end else begin
          b = pick_bin(it.value, n);
          if (bin_cnt[b] != '1) bin_cnt[b]++;
        end
      end
      FUNC_READOUT: begin
        n_readouts++;
        cmin = MIN_CAP;
        cmax = '0;
        for (int i = 0; i <= n; i++) begin
          r = '0;
          r.kind      = KIND_BIN;
          r.bin_index = 6'(i);
          r.count     = bin_cnt[i];
          if (bin_cnt[i] < cmin) cmin = bin_cnt[i];
          if (bin_cnt[i] > cmax) cmax = bin_cnt[i];
          readout_due_q.push_back(r);
        end
        r = '0;
        r.kind  = KIND_BAD;
        r.count = bad_cnt;
        if (bad_cnt < cmin) cmin = bad_cnt;
        if (bad_cnt > cmax) cmax = bad_cnt;
        readout_due_q.push_back(r);
        r = '0;
        r.kind      = KIND_SUM;
        r.count_min = anchor_reg ? '0 : cmin;
        r.count_max = cmax;
        r.last      = 1'b1;
        readout_due_q.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                n_results, name, got, want));
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (readout_due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d bin %0d count %0h",
                                got.kind, got.bin_index, got.count));
      return;
    end
    want = readout_due_q.pop_front();
    n_results++;
    check_field("kind", 32'(got.kind), 32'(want.kind));
    check_field("bin_index", 32'(got.bin_index), 32'(want.bin_index));
    check_field("count", got.count, want.count);
    check_field("count_min", got.count_min, want.count_min);
    check_field("count_max", got.count_max, want.count_max);
    check_field("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) check_result(result_o);
  end

  // ends the run when neither side nor the register port moves
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("threshold_histogram_binner_test NOT OK");
        $finish;
      end
    end
  end

  // start stays high after a transfer; the next step either sends or lowers it
  task automatic send_item(item_t it);
    @(negedge clk_i);
    start  <= 1'b1;
    item_d <= it;
    do @(posedge clk_i); while (busy);
    account_item(it);
    n_items++;
  endtask

  function automatic item_t mk_item(logic [1:0] f, logic [4:0] idx, logic signed [31:0] v);
    item_t it;
    it.func       = f;
    it.edge_index = idx;
    it.value      = v;
    return it;
  endfunction

  task automatic send_sample(logic signed [31:0] v);
    send_item(mk_item(FUNC_SAMPLE, 5'($urandom_range(31)), v));
  endtask

  task automatic send_op(logic [1:0] f);
    send_item(mk_item(f, 5'($urandom_range(31)), $urandom));
  endtask

  task automatic pause_cycles(int n);
    item_t junk;
    repeat (n) begin
      junk.func       = 2'($urandom_range(3));
      junk.edge_index = 5'($urandom_range(31));
      junk.value      = $urandom;
      @(negedge clk_i);
      start  <= 1'b0;
      item_d <= junk;
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    start <= 1'b0;
    while (readout_due_q.size() != 0) @(posedge clk_i);
  endtask

  // a sample with no result may still be in flight after the last readout
  task automatic settle();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_NUM_EDGES:   ne_reg      = data[5:0];
      CFG_BAD_VALUE:   bad_val_reg = data;
      CFG_ZERO_ANCHOR: anchor_reg  = data[0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic set_regs(logic [5:0] ne, logic signed [31:0] bad, logic anchor);
    logic [31:0] d;
    d = $urandom;
    d[5:0] = ne;
    write_reg(CFG_NUM_EDGES, d);
    write_reg(CFG_BAD_VALUE, bad);
    d = $urandom;
    d[0] = anchor;
    write_reg(CFG_ZERO_ANCHOR, d);
  endtask

  task automatic load_edges_sorted();
    logic signed [31:0] base;
    int unsigned        step;
    base = S32_MIN + $urandom_range(1 << 20);
    step = $urandom_range(1, 1 << 25);
    for (int i = 0; i < NUM_SLOTS; i++)
      send_item(mk_item(FUNC_WR_EDGE, 5'(i), base + i * step));
  endtask

  function automatic logic signed [31:0] pick_sample();
    int off;
    off = $urandom_range(2);
    case ($urandom_range(9))
      0, 1:       return bad_val_reg;
      2, 3, 4, 5: return edge_tab[$urandom_range(NUM_SLOTS - 1)] + (off - 1);
      6:          return $urandom_range(1) ? S32_MAX : S32_MIN;
      default:    return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    roll;
    it.edge_index = 5'($urandom_range(31));
    it.value      = $urandom;
    roll = $urandom_range(99);
    if (roll < 66) begin
      it.func  = FUNC_SAMPLE;
      it.value = pick_sample();
    end else if (roll < 80) begin
      it.func = FUNC_WR_EDGE;
      if ($urandom_range(1)) it.value = pick_sample();
    end else if (roll < 85) begin
      it.func = FUNC_CLEAR;
    end else begin
      it.func = FUNC_READOUT;
    end
    return it;
  endfunction

  // ---- tests ----

  task automatic test_reset_state();
    send_op(FUNC_READOUT);
    send_sample(32'sd0);
    send_sample(S32_MIN);
    send_sample(S32_MAX);
    send_op(FUNC_READOUT);
  endtask

  // edges at both extremes; samples on each edge and one step to one side of it
  task automatic test_bin_boundaries();
    logic signed [31:0] v;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case (i)
        0:       v = S32_MIN;
        1:       v = -32'sd1000;
        2:       v = 32'sd0;
        3:       v = 32'sd1000;
        4:       v = S32_MAX;
        default: v = i * 1000000;
      endcase
      send_item(mk_item(FUNC_WR_EDGE, 5'(i), v));
    end
    settle();
    set_regs(6'd5, S32_MIN, 1'b0);
    send_sample(S32_MIN);
    send_sample(S32_MIN + 1);
    send_sample(-32'sd1001);
    send_sample(-32'sd1000);
    send_sample(-32'sd1);
    send_sample(32'sd0);
    send_sample(32'sd999);
    send_sample(32'sd1000);
    send_sample(S32_MAX - 1);
    send_sample(S32_MAX);
    send_op(FUNC_READOUT);
    send_op(FUNC_CLEAR);
    send_op(FUNC_READOUT);
  endtask

  task automatic test_register_extremes();
    settle();
    set_regs(6'd63, S32_MAX, 1'b1);
    send_sample(S32_MAX);
    send_sample(32'sd5000000);
    send_sample(32'sd40000000);
    send_sample(-32'sd5);
    send_op(FUNC_READOUT);
    // counts survive a shrinking edge count
    settle();
    write_reg(CFG_NUM_EDGES, 32'd2);
    send_op(FUNC_READOUT);
    settle();
    write_reg(CFG_NUM_EDGES, 32'd32);
    send_op(FUNC_READOUT);
    settle();
    set_regs(6'd0, S32_MAX, 1'b0);
    send_sample(-32'sd5);
    send_sample(S32_MAX);
    send_op(FUNC_READOUT);
  endtask

  // both counts off zero and unanchored, so the reported minimum comes from the counts
  task automatic test_count_min();
    settle();
    set_regs(6'd0, 32'sd0, 1'b0);
    send_op(FUNC_CLEAR);
    repeat (12) send_sample(32'sd7);
    repeat (9) send_sample(32'sd0);
    send_op(FUNC_READOUT);
    send_op(FUNC_CLEAR);
  endtask

  task automatic run_random_phase(int idle_pct, int n_phase);
    item_t             it;
    logic [5:0]        ne;
    logic signed [31:0] bad;
    settle();
    case ($urandom_range(4))
      0:       ne = 6'd0;
      1:       ne = 6'd32;
      2:       ne = 6'd63;
      default: ne = 6'($urandom_range(63));
    endcase
    case ($urandom_range(4))
      0:       bad = S32_MIN;
      1:       bad = S32_MAX;
      2:       bad = 32'sd0;
      3:       bad = edge_tab[$urandom_range(NUM_SLOTS - 1)];
      default: bad = $urandom;
    endcase
    set_regs(ne, bad, 1'($urandom_range(1)));
    if ($urandom_range(1)) load_edges_sorted();
    repeat (n_phase) begin
      it = rand_item();
      send_item(it);
      if (it.func == FUNC_READOUT && $urandom_range(3) == 0)
        wait_results_done();
      else if ($urandom_range(99) < idle_pct)
        pause_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 110);
    run_random_phase(49, 110);
    run_random_phase(24, 110);
    run_random_phase(0, 110);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_NUM_EDGES;
    cfg_wdata_i = '0;
    start       = 1'b0;
    item_d      = '0;
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    bad_cnt      = '0;
    ne_reg       = '0;
    bad_val_reg  = '0;
    anchor_reg   = 1'b1;
    n_errors     = 0;
    n_items      = 0;
    n_samples    = 0;
    n_readouts   = 0;
    n_results    = 0;
    n_cfg_writes = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_bin_boundaries();
    test_register_extremes();
    test_count_min();
    test_random_traffic();
    settle();

    $display("covered %0d items: %0d samples, %0d readouts, %0d register writes",
             n_items, n_samples, n_readouts, n_cfg_writes);
    $display("checked %0d readout results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("threshold_histogram_binner_test OK");
    end else begin
      $display("threshold_histogram_binner_test NOT OK");
    end
    $finish;
  end

endmodule
